// ===== rtl/crcfc_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfc_pkg
// Shared types, character codes and CRC helpers for the CRC-16 frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package crcfc_pkg;

	// Frame delimiters and the substitute for a CRC byte that equals the end marker
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_START = 8'h23;
	localparam logic [7:0] CH_END   = 8'h24;
	localparam logic [7:0] CH_SUB   = 8'h31;

	// Reflected CRC-16 polynomial (ARC variant)
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Hard ceiling on the payload length, applied on top of the register
	localparam logic [10:0] MAX_PAYLOAD = 11'd1024;

	// Reset value of the payload length limit register
	localparam logic [10:0] MAX_LEN_RESET = 11'd1024;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_CRC       = 2'd1,
		ST_MALFORMED = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	// One result beat
	typedef struct packed {
		logic [7:0]  out_byte;
		logic        is_frame_end;
		status_t     frame_status;
		logic [10:0] payload_len;
	} res_t;

	// Fold one byte into the running CRC, one bit per step, LSB first
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Replace each CRC byte equal to the end marker by the substitute character
	function automatic logic [15:0] sub_end_marker(input logic [15:0] crc);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = crc[7:0];
		hi = crc[15:8];
		if (lo == CH_END) lo = CH_SUB;
		if (hi == CH_END) hi = CH_SUB;
		return {hi, lo};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/crcfc_in_reg.sv =====
// ----------------------------------------------------------------------------
// crcfc_in_reg
// Input register stage: captures one received byte per beat and holds it
// until the downstream stage advances.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfc_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	logic accept;

	// Take a new beat when empty or when the held byte moves on
	assign rx_ready = !valid_s1 || advance;
	assign accept   = rx_valid && rx_ready;

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the byte
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/crcfc_parser.sv =====
// ----------------------------------------------------------------------------
// crcfc_parser
// Frame state machine: hunts for the start marker, passes payload bytes while
// folding them into the CRC, captures the received CRC and reports status on
// the end marker. Also holds the payload length limit register.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfc_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [10:0] cfg_wr_data,
	input  wire logic        fire,
	input  wire logic [7:0]  byte_s1,
	output logic             res_hit,
	output crcfc_pkg::res_t  res
);

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_DATA  = 3'd1,
		PH_CRCLO = 3'd2,
		PH_CRCHI = 3'd3,
		PH_TAIL  = 3'd4
	} phase_t;

	phase_t      phase_q,  phase_d;
	logic [15:0] crc_q,    crc_d;
	logic [15:0] rcrc_q,   rcrc_d;
	logic [10:0] cnt_q,    cnt_d;
	logic        fault_q,  fault_d;
	logic [10:0] max_len_q;
	logic [10:0] limit;

	// Effective limit: smaller of register and hard ceiling
	assign limit = (max_len_q > crcfc_pkg::MAX_PAYLOAD) ? crcfc_pkg::MAX_PAYLOAD : max_len_q;

	// Next state and result for the byte in the input register
	always_comb begin
		phase_d = phase_q;
		crc_d   = crc_q;
		rcrc_d  = rcrc_q;
		cnt_d   = cnt_q;
		fault_d = fault_q;
		res_hit = 1'b0;
		res     = '0;
		unique case (phase_q)
			PH_DATA: begin
				if (byte_s1 == crcfc_pkg::CH_NUL) begin
					phase_d = PH_CRCLO;
				end else if (byte_s1 == crcfc_pkg::CH_END) begin
					res_hit = 1'b1;
					res.is_frame_end = 1'b1;
					res.frame_status = crcfc_pkg::ST_MALFORMED;
					res.payload_len  = cnt_q;
					phase_d = PH_HUNT;
				end else if (cnt_q >= limit) begin
					// drop the byte, remember the overflow
					fault_d = 1'b1;
				end else begin
					crc_d   = crcfc_pkg::crc_fold(crc_q, byte_s1);
					cnt_d   = cnt_q + 11'd1;
					res_hit = 1'b1;
					res.out_byte = byte_s1;
				end
			end
			PH_CRCLO, PH_CRCHI: begin
				if (byte_s1 == crcfc_pkg::CH_END) begin
					res_hit = 1'b1;
					res.is_frame_end = 1'b1;
					res.frame_status = crcfc_pkg::ST_MALFORMED;
					res.payload_len  = cnt_q;
					phase_d = PH_HUNT;
				end else if (phase_q == PH_CRCLO) begin
					rcrc_d  = {rcrc_q[15:8], byte_s1};
					phase_d = PH_CRCHI;
				end else begin
					rcrc_d  = {byte_s1, rcrc_q[7:0]};
					phase_d = PH_TAIL;
				end
			end
			PH_TAIL: begin
				if (byte_s1 == crcfc_pkg::CH_END) begin
					res_hit = 1'b1;
					res.is_frame_end = 1'b1;
					res.payload_len  = cnt_q;
					priority if (fault_q) begin
						res.frame_status = crcfc_pkg::ST_OVERFLOW;
					end else if (crcfc_pkg::sub_end_marker(crc_q) == rcrc_q) begin
						res.frame_status = crcfc_pkg::ST_OK;
					end else begin
						res.frame_status = crcfc_pkg::ST_CRC;
					end
					phase_d = PH_HUNT;
				end
			end
			default: begin
				// hunt: drop garbage until the start marker
				phase_d = PH_HUNT;
				if (byte_s1 == crcfc_pkg::CH_START) begin
					phase_d = PH_DATA;
					crc_d   = '0;
					rcrc_d  = '0;
					cnt_d   = '0;
					fault_d = 1'b0;
				end
			end
		endcase
	end

	// Hold frame state; advance on each byte that leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			crc_q     <= '0;
			rcrc_q    <= '0;
			cnt_q     <= '0;
			fault_q   <= 1'b0;
			max_len_q <= crcfc_pkg::MAX_LEN_RESET;
		end else begin
			if (fire) begin
				phase_q <= phase_d;
				crc_q   <= crc_d;
				rcrc_q  <= rcrc_d;
				cnt_q   <= cnt_d;
				fault_q <= fault_d;
			end
			if (cfg_wr_en) begin
				max_len_q <= cfg_wr_data;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/crcfc_out_reg.sv =====
// ----------------------------------------------------------------------------
// crcfc_out_reg
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfc_out_reg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            advance,
	input  wire logic            load_valid,
	input  wire crcfc_pkg::res_t load_data,
	output logic                 valid_s2,
	output crcfc_pkg::res_t      data_s2
);

	// Hold the valid flag; refill whenever the slot frees up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= load_valid;
		end
	end

	// Capture the result payload
	always_ff @(posedge clk) begin
		if (advance && load_valid) begin
			data_s2 <= load_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/crc16_frame_checker_top.sv =====
// Pipeline: two register stages; a byte is captured in the input register and its
// result is loaded into the result register, which drives the output.
// Throughput: one byte per cycle while results are taken. While a result waits,
// one more byte is taken into the empty input register, then input stalls.
// Reset: arst_n clears the valid flags of both stages, returns to hunting for '#', and sets the
// payload limit to 1024.
// ----------------------------------------------------------------------------
// crc16_frame_checker_top
// Framed serial receiver with reflected CRC-16 check and payload pass-through.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_frame_checker_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [10:0] cfg_wr_data,
	input  wire logic        rx_valid,
	output logic             rx_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic [7:0]       out_byte,
	output logic             is_frame_end,
	output logic [1:0]       frame_status,
	output logic [10:0]      payload_len
);

	logic            advance;
	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            fire;
	logic            res_hit;
	crcfc_pkg::res_t res_d;
	crcfc_pkg::res_t data_s2;

	// Move the pipeline when the result slot is empty or being taken
	assign advance = !res_valid || res_ready;
	assign fire    = valid_s1 && advance;

	crcfc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	crcfc_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fire        (fire),
		.byte_s1     (byte_s1),
		.res_hit     (res_hit),
		.res         (res_d)
	);

	crcfc_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.load_valid (fire && res_hit),
		.load_data  (res_d),
		.valid_s2   (res_valid),
		.data_s2    (data_s2)
	);

	// Unpack the result beat
	assign out_byte     = data_s2.out_byte;
	assign is_frame_end = data_s2.is_frame_end;
	assign frame_status = data_s2.frame_status;
	assign payload_len  = data_s2.payload_len;

endmodule

`default_nettype wire
